[design/assert_macros.svh]
// Assertion helpers used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, ignored while reset is asserted
`define SBL_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: check failed");

// Clocked check that also holds during reset
`define SBL_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`endif

[design/sbl_pkg.sv]
`default_nettype none
package sbl_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int ID_BITS_DEF     = 16;
    // Width of index and count fields in the cell control word
    localparam int CTRL_W          = 7;

    localparam logic [15:0] ONE_Q15        = 16'h8000;
    localparam logic [4:0]  CAP_RESET      = 5'd16;
    localparam logic [6:0]  THR_RESET      = 7'd80;
    localparam logic [31:0] INTERVAL_RESET = 32'd300;

    // Operation codes of the input transaction
    localparam logic [2:0] MODE_ADD     = 3'd0;
    localparam logic [2:0] MODE_ACCESS  = 3'd1;
    localparam logic [2:0] MODE_GET     = 3'd2;
    localparam logic [2:0] MODE_DECAY   = 3'd3;
    localparam logic [2:0] MODE_CONSOL  = 3'd4;
    localparam logic [2:0] MODE_CLEAR   = 3'd5;
    localparam logic [2:0] MODE_STATS   = 3'd6;
    localparam logic [2:0] MODE_TICK    = 3'd7;

    // Register indexes on the config port
    localparam logic [1:0] REG_CAPACITY  = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_INTERVAL  = 2'd2;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_WRITE,
        CELL_DECAY,
        CELL_SORT
    } cell_op_t;

    // Control word broadcast to every cell of the chain
    typedef struct packed {
        cell_op_t          op;
        logic [CTRL_W-1:0] sel;
        logic [CTRL_W-1:0] fill;
        logic              phase;
        logic [15:0]       wr_score;
        logic [15:0]       keep;
    } cell_ctrl_t;

    // Saturate a signed value to the Q1.15 range 0..1.0
    function automatic logic [15:0] clamp_q15(input logic signed [17:0] v);
        logic [15:0] r;
        if (v < 18'sd0) begin
            r = 16'd0;
        end else if (v > 18'sd32768) begin
            r = ONE_Q15;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[design/sbl_cell.sv]
`default_nettype none
module sbl_cell
    import sbl_pkg::*;
#(
    parameter int IDX     = 0,
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire cell_ctrl_t         ctrl,
    input  wire logic [ID_BITS-1:0] wr_id,
    input  wire logic [ID_BITS-1:0] up_id,
    input  wire logic [15:0]        up_score,
    input  wire logic [ID_BITS-1:0] dn_id,
    input  wire logic [15:0]        dn_score,
    output logic      [ID_BITS-1:0] id_out,
    output logic      [15:0]        score_out
);

    localparam logic [CTRL_W-1:0] MY  = CTRL_W'(IDX);
    localparam logic [CTRL_W-1:0] MY1 = CTRL_W'(IDX + 1);
    localparam logic              ODD = 1'(IDX % 2);

    logic [ID_BITS-1:0] id_reg, id_next;
    logic [15:0]        score_reg, score_next;
    logic [31:0]        product;

    // Per-cell update: shift, load, scale or compare-exchange with a neighbor
    always_comb begin
        id_next    = id_reg;
        score_next = score_reg;
        product    = 32'(score_reg) * 32'(ctrl.keep);
        unique case (ctrl.op)
            CELL_HOLD: begin
            end
            CELL_SHIFT: begin
                if (MY >= ctrl.sel) begin
                    id_next    = up_id;
                    score_next = up_score;
                end
            end
            CELL_WRITE: begin
                if (MY == ctrl.sel) begin
                    id_next    = wr_id;
                    score_next = ctrl.wr_score;
                end
            end
            CELL_DECAY: begin
                score_next = product[30:15];
            end
            CELL_SORT: begin
                if (ODD == ctrl.phase) begin
                    // left side of a pair: take the larger neighbor
                    if (MY1 < ctrl.fill && score_reg < up_score) begin
                        id_next    = up_id;
                        score_next = up_score;
                    end
                end else if (IDX != 0 && MY < ctrl.fill && dn_score < score_reg) begin
                    id_next    = dn_id;
                    score_next = dn_score;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        id_reg    <= id_next;
        score_reg <= score_next;
    end

    assign id_out    = id_reg;
    assign score_out = score_reg;

endmodule
`default_nettype wire

[design/sbl_div.sv]
`default_nettype none
module sbl_div
    import sbl_pkg::*;
#(
    parameter int NW = 21,
    parameter int DW = 5
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [NW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    output logic               done,
    output logic      [NW-1:0] quotient
);

    localparam int CNTW = $clog2(NW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [DW-1:0]   div_reg, div_next;
    logic [NW-1:0]   quo_reg, quo_next;
    logic [DW:0]     trial;
    logic            ge;

    // Restoring division, one quotient bit per cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        trial     = {rem_reg, quo_reg[NW-1]};
        ge        = trial >= {1'b0, div_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNTW'(NW);
            rem_next  = '0;
            div_next  = divisor;
            quo_next  = dividend;
        end else if (busy_reg) begin
            rem_next = ge ? DW'(trial - {1'b0, div_reg}) : trial[DW-1:0];
            quo_next = {quo_reg[NW-2:0], ge};
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

[design/scored_buffer_lowest_evict.sv]
// Each input closes with a status result. Access, get, decay, tick, and a clear or
// consolidate with nothing to evict go straight to it; an add appends, first scanning for
// and evicting the lowest score when full; consolidate sorts and evicts; stats sums, divides.
// Throughput: one transaction at a time; a new input is accepted once the status is out.
// Reset (synchronous, active low) clears count, tick counter, output valid and restores the
// register defaults; entry contents are not cleared.
`default_nettype none
module scored_buffer_lowest_evict
    import sbl_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_mode,
    input  wire logic [15:0]        s_item_id,
    input  wire logic signed [16:0] s_score_in,
    input  wire logic [3:0]         s_slot_index,
    input  wire logic signed [16:0] s_boost,
    input  wire logic signed [16:0] s_decay_rate,
    input  wire logic               s_consolidate_first,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_kind,
    output logic                    m_status,
    output logic      [15:0]        m_item_out,
    output logic      [15:0]        m_score_out,
    output logic      [4:0]         m_entry_count_out,
    output logic      [15:0]        m_avg_score,
    output logic      [31:0]        m_ticks_since,
    output logic                    m_needs_consolidation,
    output logic                    m_last,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int IW   = $clog2(MAX_ENTRIES);
    localparam int CMPW = (CW > 5) ? CW : 5;
    localparam int SW   = 16 + CW;
    localparam logic [4:0] CAP_INIT =
        (MAX_ENTRIES < 16) ? 5'(MAX_ENTRIES) : CAP_RESET;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_EXEC   = 4'd1;
    localparam logic [3:0] ST_SCAN   = 4'd2;
    localparam logic [3:0] ST_EVICT  = 4'd3;
    localparam logic [3:0] ST_APPEND = 4'd4;
    localparam logic [3:0] ST_SORT   = 4'd5;
    localparam logic [3:0] ST_TAIL   = 4'd6;
    localparam logic [3:0] ST_SUM    = 4'd7;
    localparam logic [3:0] ST_DIV    = 4'd8;
    localparam logic [3:0] ST_STATUS = 4'd9;

    // Control state
    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [31:0]   tick_reg, tick_next;
    logic [4:0]    cap_reg, cap_next;
    logic [6:0]    thr_reg, thr_next;
    logic [31:0]   intv_reg, intv_next;
    logic          m_valid_reg;

    // Transaction payload and work registers
    logic [2:0]         mode_reg, mode_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    logic [15:0]        sin_reg, sin_next;
    logic [3:0]         slot_reg, slot_next;
    logic signed [16:0] boost_reg, boost_next;
    logic [15:0]        keep_reg, keep_next;
    logic               cf_reg, cf_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [IW-1:0]      low_reg, low_next;
    logic [15:0]        low_sc_reg, low_sc_next;
    logic [SW-1:0]      sum_reg, sum_next;
    logic               res_status_reg, res_status_next;
    logic [ID_BITS-1:0] res_item_reg, res_item_next;
    logic [15:0]        res_score_reg, res_score_next;
    logic [15:0]        avg_reg, avg_next;

    // Output register payload
    logic        m_kind_reg, m_status_reg, m_needs_reg, m_last_reg;
    logic [15:0] m_item_reg, m_score_reg, m_avg_reg;
    logic [4:0]  m_count_reg;
    logic [31:0] m_ticks_reg;

    // Cell chain
    cell_ctrl_t         cctl;
    logic [ID_BITS-1:0] wr_id;
    logic [ID_BITS-1:0] cid [MAX_ENTRIES];
    logic [15:0]        csc [MAX_ENTRIES];
    logic [ID_BITS-1:0] up_id [MAX_ENTRIES];
    logic [15:0]        up_sc [MAX_ENTRIES];
    logic [ID_BITS-1:0] dn_id [MAX_ENTRIES];
    logic [15:0]        dn_sc [MAX_ENTRIES];

    logic [IW-1:0]      rd_idx;
    logic [ID_BITS-1:0] rd_id;
    logic [15:0]        rd_sc;
    logic [CW-1:0]      fill_m1;
    logic               cfg_wr;
    logic               out_free;
    logic               load_ev, load_st;
    logic               oob, fill_ge_cap, gt_tgt, needs;
    logic [14:0]        tgt_prod;
    logic [4:0]         tgt_raw, target;
    logic signed [17:0] acc_sum;
    logic [15:0]        acc_new;
    logic [4:0]         cap_wr;
    logic               div_start, div_done;
    logic [SW-1:0]      div_q;

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
            if (g == MAX_ENTRIES - 1) begin : g_top
                assign up_id[g] = '0;
                assign up_sc[g] = '0;
            end else begin : g_mid
                assign up_id[g] = cid[g+1];
                assign up_sc[g] = csc[g+1];
            end
            if (g == 0) begin : g_bot
                assign dn_id[g] = '0;
                assign dn_sc[g] = '0;
            end else begin : g_low
                assign dn_id[g] = cid[g-1];
                assign dn_sc[g] = csc[g-1];
            end
            sbl_cell #(
                .IDX     (g),
                .ID_BITS (ID_BITS)
            ) u_cell (
                .aclk      (aclk),
                .ctrl      (cctl),
                .wr_id     (wr_id),
                .up_id     (up_id[g]),
                .up_score  (up_sc[g]),
                .dn_id     (dn_id[g]),
                .dn_score  (dn_sc[g]),
                .id_out    (cid[g]),
                .score_out (csc[g])
            );
        end
    endgenerate

    sbl_div #(
        .NW (SW),
        .DW (CW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Status terms
    assign fill_m1     = fill_reg - CW'(1);
    assign out_free    = !m_valid_reg || m_ready;
    assign cfg_wr      = psel && penable && pwrite && pready;
    assign oob         = CMPW'(slot_reg) >= CMPW'(fill_reg);
    assign fill_ge_cap = CMPW'(fill_reg) >= CMPW'(cap_reg);
    // floor(cap*3/5) as cap*615 >> 10, exact for cap below 32
    assign tgt_prod    = 15'(cap_reg) * 15'd615;
    assign tgt_raw     = tgt_prod[14:10];
    assign target      = (tgt_raw == 5'd0) ? 5'd1 : tgt_raw;
    assign gt_tgt      = CMPW'(fill_reg) > CMPW'(target);
    assign needs       = (16'(fill_reg) * 16'd100 >= 16'(thr_reg) * 16'(cap_reg)) ||
                         (tick_reg >= intv_reg);
    assign acc_sum     = $signed({2'b00, rd_sc}) + $signed({boost_reg[16], boost_reg});
    assign acc_new     = clamp_q15(acc_sum);
    assign cap_wr      = (pwdata[4:0] == 5'd0) ? 5'd1 :
                         (CMPW'(pwdata[4:0]) > CMPW'(MAX_ENTRIES)) ? 5'(MAX_ENTRIES) :
                         pwdata[4:0];

    // Entry read port over the chain
    always_comb begin
        unique case (state_reg)
            ST_SCAN, ST_SUM: rd_idx = idx_reg[IW-1:0];
            ST_EVICT:        rd_idx = low_reg;
            ST_TAIL:         rd_idx = fill_m1[IW-1:0];
            default:         rd_idx = IW'(slot_reg);
        endcase
    end
    assign rd_id = cid[rd_idx];
    assign rd_sc = csc[rd_idx];

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        tick_next       = tick_reg;
        cap_next        = cap_reg;
        thr_next        = thr_reg;
        intv_next       = intv_reg;
        mode_next       = mode_reg;
        id_next         = id_reg;
        sin_next        = sin_reg;
        slot_next       = slot_reg;
        boost_next      = boost_reg;
        keep_next       = keep_reg;
        cf_next         = cf_reg;
        idx_next        = idx_reg;
        low_next        = low_reg;
        low_sc_next     = low_sc_reg;
        sum_next        = sum_reg;
        res_status_next = res_status_reg;
        res_item_next   = res_item_reg;
        res_score_next  = res_score_reg;
        avg_next        = avg_reg;
        cctl.op         = CELL_HOLD;
        cctl.sel        = '0;
        cctl.fill       = CTRL_W'(fill_reg);
        cctl.phase      = idx_reg[0];
        cctl.wr_score   = sin_reg;
        cctl.keep       = keep_reg;
        wr_id           = id_reg;
        load_ev         = 1'b0;
        load_st         = 1'b0;
        div_start       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mode_next       = s_mode;
                    id_next         = ID_BITS'(s_item_id);
                    sin_next        = clamp_q15({s_score_in[16], s_score_in});
                    slot_next       = s_slot_index;
                    boost_next      = s_boost;
                    keep_next       = ONE_Q15 - clamp_q15({s_decay_rate[16], s_decay_rate});
                    cf_next         = s_consolidate_first;
                    res_status_next = 1'b0;
                    res_item_next   = '0;
                    res_score_next  = '0;
                    avg_next        = '0;
                    state_next      = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_STATUS;
                unique case (mode_reg)
                    MODE_ADD: begin
                        if (fill_ge_cap && fill_reg != '0) begin
                            low_next    = '0;
                            low_sc_next = csc[0];
                            idx_next    = CW'(1);
                            state_next  = ST_SCAN;
                        end else begin
                            state_next = ST_APPEND;
                        end
                    end
                    MODE_ACCESS: begin
                        if (oob) begin
                            res_status_next = 1'b1;
                        end else begin
                            cctl.op        = CELL_WRITE;
                            cctl.sel       = CTRL_W'(slot_reg);
                            cctl.wr_score  = acc_new;
                            wr_id          = rd_id;
                            res_item_next  = rd_id;
                            res_score_next = acc_new;
                        end
                    end
                    MODE_GET: begin
                        if (oob) begin
                            res_status_next = 1'b1;
                        end else begin
                            res_item_next  = rd_id;
                            res_score_next = rd_sc;
                        end
                    end
                    MODE_DECAY: begin
                        cctl.op = CELL_DECAY;
                    end
                    MODE_CONSOL: begin
                        if (gt_tgt) begin
                            idx_next   = '0;
                            state_next = ST_SORT;
                        end
                    end
                    MODE_CLEAR: begin
                        if (cf_reg && gt_tgt) begin
                            idx_next   = '0;
                            state_next = ST_SORT;
                        end else begin
                            fill_next = '0;
                        end
                    end
                    MODE_STATS: begin
                        if (fill_reg != '0) begin
                            idx_next   = '0;
                            sum_next   = '0;
                            state_next = ST_SUM;
                        end
                    end
                    MODE_TICK: begin
                        if (tick_reg != '1) begin
                            tick_next = tick_reg + 32'd1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_SCAN: begin
                // first lowest score wins, later equal scores do not replace it
                if (idx_reg < fill_reg) begin
                    if (rd_sc < low_sc_reg) begin
                        low_next    = idx_reg[IW-1:0];
                        low_sc_next = rd_sc;
                    end
                    idx_next = idx_reg + CW'(1);
                end else begin
                    state_next = ST_EVICT;
                end
            end
            ST_EVICT: begin
                if (out_free) begin
                    load_ev    = 1'b1;
                    cctl.op    = CELL_SHIFT;
                    cctl.sel   = CTRL_W'(low_reg);
                    fill_next  = fill_m1;
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND: begin
                if (CMPW'(fill_reg) < CMPW'(MAX_ENTRIES)) begin
                    cctl.op   = CELL_WRITE;
                    cctl.sel  = CTRL_W'(fill_reg);
                    fill_next = fill_reg + CW'(1);
                end
                res_item_next  = id_reg;
                res_score_next = sin_reg;
                state_next     = ST_STATUS;
            end
            ST_SORT: begin
                cctl.op = CELL_SORT;
                if (idx_reg == CW'(MAX_ENTRIES - 1)) begin
                    state_next = ST_TAIL;
                end else begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            ST_TAIL: begin
                if (gt_tgt) begin
                    if (out_free) begin
                        load_ev   = 1'b1;
                        fill_next = fill_m1;
                    end
                end else begin
                    tick_next = '0;
                    if (mode_reg == MODE_CLEAR) begin
                        fill_next = '0;
                    end
                    state_next = ST_STATUS;
                end
            end
            ST_SUM: begin
                if (idx_reg < fill_reg) begin
                    sum_next = sum_reg + SW'(rd_sc);
                    idx_next = idx_reg + CW'(1);
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    avg_next   = div_q[15:0];
                    state_next = ST_STATUS;
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    load_st    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Register writes from the config port
        if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_CAPACITY: begin
                    if (fill_reg == '0) begin
                        cap_next = cap_wr;
                    end
                end
                REG_THRESHOLD: thr_next = pwdata[6:0];
                REG_INTERVAL:  intv_next = pwdata;
                default: begin
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            tick_reg    <= '0;
            cap_reg     <= CAP_INIT;
            thr_reg     <= THR_RESET;
            intv_reg    <= INTERVAL_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            tick_reg  <= tick_next;
            cap_reg   <= cap_next;
            thr_reg   <= thr_next;
            intv_reg  <= intv_next;
            if (load_ev || load_st) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and work registers
    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        id_reg         <= id_next;
        sin_reg        <= sin_next;
        slot_reg       <= slot_next;
        boost_reg      <= boost_next;
        keep_reg       <= keep_next;
        cf_reg         <= cf_next;
        idx_reg        <= idx_next;
        low_reg        <= low_next;
        low_sc_reg     <= low_sc_next;
        sum_reg        <= sum_next;
        res_status_reg <= res_status_next;
        res_item_reg   <= res_item_next;
        res_score_reg  <= res_score_next;
        avg_reg        <= avg_next;
        if (load_ev) begin
            m_kind_reg   <= 1'b1;
            m_status_reg <= 1'b0;
            m_item_reg   <= 16'(rd_id);
            m_score_reg  <= rd_sc;
            m_count_reg  <= 5'(fill_m1);
            m_avg_reg    <= '0;
            m_ticks_reg  <= '0;
            m_needs_reg  <= 1'b0;
            m_last_reg   <= 1'b0;
        end else if (load_st) begin
            m_kind_reg   <= 1'b0;
            m_status_reg <= res_status_reg;
            m_item_reg   <= 16'(res_item_reg);
            m_score_reg  <= res_score_reg;
            m_count_reg  <= 5'(fill_reg);
            m_avg_reg    <= avg_reg;
            m_ticks_reg  <= tick_reg;
            m_needs_reg  <= needs;
            m_last_reg   <= 1'b1;
        end
    end

    // Register readback
    always_comb begin
        unique case (paddr[3:2])
            REG_CAPACITY:  prdata = 32'(cap_reg);
            REG_THRESHOLD: prdata = 32'(thr_reg);
            REG_INTERVAL:  prdata = intv_reg;
            default:       prdata = '0;
        endcase
    end

    assign pready                = 1'b1;
    assign s_ready               = (state_reg == ST_IDLE);
    assign m_valid               = m_valid_reg;
    assign m_kind                = m_kind_reg;
    assign m_status              = m_status_reg;
    assign m_item_out            = m_item_reg;
    assign m_score_out           = m_score_reg;
    assign m_entry_count_out     = m_count_reg;
    assign m_avg_score           = m_avg_reg;
    assign m_ticks_since         = m_ticks_reg;
    assign m_needs_consolidation = m_needs_reg;
    assign m_last                = m_last_reg;

endmodule
`default_nettype wire

[design/sbl_check.sv]
`default_nettype none
`include "assert_macros.svh"
module sbl_check (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_kind,
    input wire logic        m_status,
    input wire logic [15:0] m_item_out,
    input wire logic [15:0] m_score_out,
    input wire logic        m_last
);

    // A stalled result transaction stays valid and keeps its item
    `SBL_ASSERT(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_item_out))
    // Eviction reports never close a transaction and never carry an error
    `SBL_ASSERT(a_evict_flags, aclk, aresetn, m_valid && m_kind |-> !m_last && !m_status)
    // Out-of-range access and get report no entry data
    `SBL_ASSERT(a_err_zero, aclk, aresetn,
        m_valid && m_status |-> m_item_out == 16'd0 && m_score_out == 16'd0)
    // Scores stay within Q1.15 range 0..1.0
    `SBL_ASSERT(a_score_rng, aclk, aresetn, m_valid |-> m_score_out <= 16'h8000)

endmodule

bind scored_buffer_lowest_evict sbl_check u_sbl_check (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_kind      (m_kind),
    .m_status    (m_status),
    .m_item_out  (m_item_out),
    .m_score_out (m_score_out),
    .m_last      (m_last)
);
`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps

// Expected-result store and predictor for the lowest-score replacement buffer
class sbl_scoreboard;
    typedef struct packed {
        logic        kind;
        logic        status;
        logic [15:0] item;
        logic [15:0] score;
        logic [4:0]  count;
        logic [15:0] avg;
        logic [31:0] ticks;
        logic        needs;
        logic        last;
    } sbl_result_t;

    logic [15:0] ids[16];
    logic [15:0] scores[16];
    int unsigned fill;
    logic [31:0] ticks;
    int unsigned cap;
    int unsigned thr;
    logic [31:0] interval;
    sbl_result_t pending[$];
    int errors;

    function new();
        fill = 0;
        ticks = 0;
        cap = 16;
        thr = 80;
        interval = 300;
        errors = 0;
    endfunction

    function int unsigned clamp(int v);
        if (v < 0) return 0;
        if (v > 32768) return 32768;
        return v;
    endfunction

    function void set_reg(int idx, logic [31:0] val);
        int unsigned c;
        c = val[4:0];
        if (idx == 0) begin
            if (fill != 0) return;
            if (c < 1) c = 1;
            if (c > 16) c = 16;
            cap = c;
        end else if (idx == 1) begin
            thr = val[6:0];
        end else begin
            interval = val;
        end
    endfunction

    function bit needs_flag();
        return (fill * 100 >= thr * cap) || (ticks >= interval);
    endfunction

    function void push(logic k, logic st, logic [15:0] it, logic [15:0] sc,
                       logic [15:0] av, logic [31:0] tk, logic nd, logic ls);
        sbl_result_t r;
        r.kind = k;
        r.status = st;
        r.item = it;
        r.score = sc;
        r.count = fill;
        r.avg = av;
        r.ticks = tk;
        r.needs = nd;
        r.last = ls;
        pending.push_back(r);
    endfunction

    function void evict(int unsigned idx);
        logic [15:0] id;
        logic [15:0] sc;
        id = ids[idx];
        sc = scores[idx];
        for (int i = idx; i + 1 < fill; i++) begin
            ids[i] = ids[i + 1];
            scores[i] = scores[i + 1];
        end
        fill--;
        push(1, 0, id, sc, 0, 0, 0, 0);
    endfunction

    function void shrink();
        int unsigned target;
        logic [15:0] t;
        target = cap * 3 / 5;
        if (target < 1) target = 1;
        if (fill == 0 || fill <= target) return;
        for (int i = 0; i + 1 < fill; i++)
            for (int j = 0; j + 1 < fill - i; j++)
                if (scores[j] < scores[j + 1]) begin
                    t = ids[j]; ids[j] = ids[j + 1]; ids[j + 1] = t;
                    t = scores[j]; scores[j] = scores[j + 1]; scores[j + 1] = t;
                end
        while (fill > target) evict(fill - 1);
        ticks = 0;
    endfunction

    // Note an accepted input transaction and queue what it should produce
    function void note_input(logic [2:0] mode, logic [15:0] id, logic signed [16:0] sc_in,
                             logic [3:0] idx, logic signed [16:0] boost,
                             logic signed [16:0] rate, logic cf);
        logic [15:0] item;
        logic [15:0] score;
        logic [15:0] avg;
        logic        status;
        int unsigned low;
        int unsigned keep;
        longint unsigned sum;
        item = 0; score = 0; avg = 0; status = 0;
        case (mode)
            sbl_pkg::MODE_ADD: begin
                score = clamp(int'(sc_in));
                if (fill >= cap && fill > 0) begin
                    low = 0;
                    for (int i = 1; i < fill; i++) if (scores[i] < scores[low]) low = i;
                    evict(low);
                end
                if (fill < 16) begin
                    ids[fill] = id;
                    scores[fill] = score;
                    fill++;
                end
                item = id;
            end
            sbl_pkg::MODE_ACCESS, sbl_pkg::MODE_GET: begin
                if (idx >= fill) begin
                    status = 1;
                end else begin
                    if (mode == sbl_pkg::MODE_ACCESS)
                        scores[idx] = clamp(int'(scores[idx]) + int'(boost));
                    item = ids[idx];
                    score = scores[idx];
                end
            end
            sbl_pkg::MODE_DECAY: begin
                keep = 32768 - clamp(int'(rate));
                for (int i = 0; i < fill; i++) scores[i] = (longint'(scores[i]) * keep) >> 15;
            end
            sbl_pkg::MODE_CONSOL: shrink();
            sbl_pkg::MODE_CLEAR: begin
                if (cf) shrink();
                fill = 0;
            end
            sbl_pkg::MODE_STATS: begin
                if (fill > 0) begin
                    sum = 0;
                    for (int i = 0; i < fill; i++) sum += scores[i];
                    avg = sum / fill;
                end
            end
            default: if (ticks != 32'hFFFF_FFFF) ticks++;
        endcase
        push(0, status, item, score, avg, ticks, needs_flag(), 1);
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endfunction

    // Compare one accepted result transaction with the oldest expectation
    function void check_result(sbl_result_t got);
        sbl_result_t want;
        if (pending.size() == 0) begin
            report("unexpected result", 0, 0);
            return;
        end
        want = pending.pop_front();
        if (got.kind != want.kind) report("kind", got.kind, want.kind);
        if (got.status != want.status) report("status", got.status, want.status);
        if (got.item != want.item) report("item_out", got.item, want.item);
        if (got.score != want.score) report("score_out", got.score, want.score);
        if (got.count != want.count) report("entry_count", got.count, want.count);
        if (got.avg != want.avg) report("avg_score", got.avg, want.avg);
        if (got.ticks != want.ticks) report("ticks_since", got.ticks, want.ticks);
        if (got.needs != want.needs) report("needs", got.needs, want.needs);
        if (got.last != want.last) report("last", got.last, want.last);
    endfunction
endclass

module testbench;
    import sbl_pkg::*;

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic [2:0]         s_mode = 0;
    logic [15:0]        s_item_id = 0;
    logic signed [16:0] s_score_in = 0;
    logic [3:0]         s_slot_index = 0;
    logic signed [16:0] s_boost = 0;
    logic signed [16:0] s_decay_rate = 0;
    logic               s_consolidate_first = 0;
    logic               m_valid;
    logic               m_ready = 0;
    logic               m_kind;
    logic               m_status;
    logic [15:0]        m_item_out;
    logic [15:0]        m_score_out;
    logic [4:0]         m_entry_count_out;
    logic [15:0]        m_avg_score;
    logic [31:0]        m_ticks_since;
    logic               m_needs_consolidation;
    logic               m_last;
    logic               psel = 0;
    logic               penable = 0;
    logic               pwrite = 0;
    logic [3:0]         paddr = 0;
    logic [31:0]        pwdata = 0;
    logic [31:0]        prdata;
    logic               pready;

    sbl_scoreboard buffer_model = new();
    bit sink_hold = 0;
    bit stim_done = 0;
    logic [15:0] live_ids[$];

    always #6 aclk = ~aclk;

    scored_buffer_lowest_evict i_dut (.*);

    // Result side: random stalls, plus a forced long hold-off
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            buffer_model.check_result({m_kind, m_status, m_item_out, m_score_out,
                                       m_entry_count_out, m_avg_score, m_ticks_since,
                                       m_needs_consolidation, m_last});
        end
        if (sink_hold) m_ready <= 0;
        else if ($urandom_range(0, 3) == 0) m_ready <= 0;
        else m_ready <= ($urandom_range(0, 40) != 0) || !m_ready;
    end

    task automatic gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0) n = 0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic send_op(logic [2:0] mode, logic [15:0] id, logic signed [16:0] sc,
                           logic [3:0] idx, logic signed [16:0] boost,
                           logic signed [16:0] rate, logic cf);
        s_valid <= 1;
        s_mode <= mode;
        s_item_id <= id;
        s_score_in <= sc;
        s_slot_index <= idx;
        s_boost <= boost;
        s_decay_rate <= rate;
        s_consolidate_first <= cf;
        do @(posedge aclk); while (!s_ready);
        buffer_model.note_input(mode, id, sc, idx, boost, rate, cf);
        s_valid <= 0;
        // the block is busy for at least this cycle anyway
        @(posedge aclk);
        gap();
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel <= 1;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        do @(posedge aclk); while (!pready);
        buffer_model.set_reg(idx, val);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        @(posedge aclk);
    endtask

    // Wait until every expected result has arrived, then let the block settle
    task automatic drain();
        while (buffer_model.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic rand_op(bit bursty);
        int pick;
        logic [3:0] idx;
        pick = $urandom_range(0, 99);
        idx = (buffer_model.fill > 0 && $urandom_range(0, 5) != 0)
              ? 4'($urandom_range(0, buffer_model.fill - 1)) : 4'($urandom);
        if (pick < (bursty ? 60 : 35))
            send_op(MODE_ADD, 16'($urandom), 17'($urandom_range(0, 6) == 0 ? $urandom
                    : $urandom_range(0, 32768)), 4'($urandom), 17'($urandom),
                    17'($urandom), 1'($urandom));
        else if (pick < 55)
            send_op(MODE_ACCESS, 16'($urandom), 17'($urandom), idx,
                    17'($urandom_range(0, 32768 * 2) - 32768), 17'($urandom), 1'($urandom));
        else if (pick < 65)
            send_op(MODE_GET, 16'($urandom), 17'($urandom), idx, 17'($urandom),
                    17'($urandom), 1'($urandom));
        else if (pick < 72)
            send_op(MODE_DECAY, 16'($urandom), 17'($urandom), idx, 17'($urandom),
                    17'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 8000)),
                    1'($urandom));
        else if (pick < 80)
            send_op(MODE_CONSOL, 16'($urandom), 17'($urandom), idx, 17'($urandom),
                    17'($urandom), 1'($urandom));
        else if (pick < 84)
            send_op(MODE_CLEAR, 16'($urandom), 17'($urandom), idx, 17'($urandom),
                    17'($urandom), 1'($urandom));
        else if (pick < 90)
            send_op(MODE_STATS, 16'($urandom), 17'($urandom), idx, 17'($urandom),
                    17'($urandom), 1'($urandom));
        else
            send_op(MODE_TICK, 16'($urandom), 17'($urandom), idx, 17'($urandom),
                    17'($urandom), 1'($urandom));
    endtask

    task automatic clear_all();
        send_op(MODE_CLEAR, 0, 0, 0, 0, 0, 0);
        drain();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: field extremes and each operation on the reset settings
        send_op(MODE_GET, 0, 0, 0, 0, 0, 0);
        send_op(MODE_STATS, 0, 0, 0, 0, 0, 0);
        send_op(MODE_CONSOL, 0, 0, 0, 0, 0, 0);
        send_op(MODE_ADD, 16'hFFFF, 17'h1FFFF, 4'hF, 0, 0, 0);
        send_op(MODE_ADD, 16'h0000, 17'h0FFFF, 0, 0, 0, 0);
        send_op(MODE_ADD, 16'h1234, 17'sd32768, 0, 0, 0, 0);
        send_op(MODE_ADD, 16'h5555, 17'sd100, 0, 0, 0, 0);
        send_op(MODE_ACCESS, 0, 0, 1, 17'sd32767, 0, 0);
        send_op(MODE_ACCESS, 0, 0, 2, -17'sd32768, 0, 0);
        send_op(MODE_ACCESS, 0, 0, 3, 17'sd200, 0, 0);
        send_op(MODE_ACCESS, 0, 0, 4'hF, 17'sd5, 0, 0);
        send_op(MODE_GET, 0, 0, 3, 0, 0, 0);
        send_op(MODE_GET, 0, 0, 4'hF, 0, 0, 0);
        send_op(MODE_DECAY, 0, 0, 0, 0, 17'sd16384, 0);
        send_op(MODE_DECAY, 0, 0, 0, 0, 17'h1FFFF, 0);
        send_op(MODE_DECAY, 0, 0, 0, 0, 17'h0FFFF, 0);
        send_op(MODE_STATS, 0, 0, 0, 0, 0, 0);
        send_op(MODE_TICK, 0, 0, 0, 0, 0, 0);
        send_op(MODE_CLEAR, 0, 0, 0, 0, 0, 1);
        drain();

        // Capacity extremes, ignored write while not empty, threshold and interval corners
        write_reg(REG_CAPACITY, 32'd0);
        write_reg(REG_THRESHOLD, 32'd0);
        write_reg(REG_INTERVAL, 32'd0);
        for (int i = 0; i < 4; i++) send_op(MODE_ADD, 16'(i), 17'(i * 1000), 0, 0, 0, 0);
        drain();
        write_reg(REG_CAPACITY, 32'd5);
        send_op(MODE_CLEAR, 0, 0, 0, 0, 0, 1);
        drain();
        write_reg(REG_CAPACITY, 32'h1F);
        write_reg(REG_THRESHOLD, 32'h7F);
        write_reg(REG_INTERVAL, 32'hFFFF_FFFF);

        // Long receiver hold-off while adds keep arriving
        fork
            begin
                sink_hold = 1;
                repeat (400) @(posedge aclk);
                sink_hold = 0;
            end
            for (int i = 0; i < 30; i++)
                send_op(MODE_ADD, 16'($urandom), 17'($urandom_range(0, 32768)), 0, 0, 0, 0);
        join
        clear_all();

        // Random phases over several settings
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_CAPACITY, 32'($urandom_range(1, 16)));
            write_reg(REG_THRESHOLD, 32'($urandom_range(0, 127)));
            write_reg(REG_INTERVAL, ph == 2 ? 32'hFFFF_FFFF : 32'($urandom_range(0, 40)));
            for (int n = 0; n < 65; n++) rand_op(n < 32);
            clear_all();
        end
        write_reg(REG_CAPACITY, 32'd16);
        write_reg(REG_THRESHOLD, 32'd80);
        write_reg(REG_INTERVAL, 32'd300);
        for (int n = 0; n < 40; n++) rand_op(1);
        drain();

        if (buffer_model.errors == 0 && buffer_model.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Run limit
    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

[filelist.f]
+incdir+design
design/sbl_pkg.sv
design/sbl_cell.sv
design/sbl_div.sv
design/scored_buffer_lowest_evict.sv
design/sbl_check.sv
sim/testbench.sv
